@@ hw/rtl/ibp_pkg.sv @@
// Package for the Ising Boltzmann probability block: modes, states and constants.
package ibp_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_PART  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WR1,
    S_WR2,
    S_PREAD,
    S_PACC,
    S_XINIT,
    S_QRED,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_TERM,
    S_SCALE,
    S_ROUND,
    S_ZACC,
    S_PDIV,
    S_DONE
  } state_t;

  localparam logic [36:0] LN2_Q30     = 37'd744261118;
  localparam logic [3:0]  EXP_TERMS   = 4'd12;
  localparam logic [0:0]  REG_SPIN_COUNT = 1'b0;
  localparam logic        STATUS_OK   = 1'b0;
  localparam logic        STATUS_NOZ  = 1'b1;
  localparam int          ONE_Q14     = 16384;
  localparam logic [3:0]  SPIN_RESET  = 4'd8;

endpackage

@@ hw/rtl/ising_boltzmann_probability.sv @@
// Top level: Ising pair energy, partition sum and Boltzmann probability unit.
// One word is handled at a time, sequenced over the coupling memory (one
// synchronous read per pair). A query walks the P = n(n-1)/2 pairs, does
// the range reduction of exp and its series, each term by a bit serial
// divide, and then, when needed, the probability divide. The partition run
// repeats the pair walk and exp for all 2^n configurations. Results wait in
// an output register, so the next word is taken while one is still pending.
module ising_boltzmann_probability #(
  parameter int MAX_SPINS     = 8,
  parameter int COUPLING_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // row_index[2:0], col_index[5:3], coupling_value[21:6],
                                  // config_index[29:22], zero
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // energy[19:0], probability[36:20], partition_sum[97:37],
                                  // zero
  output logic [0:0]   m_tuser,   // status[0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ibp_pkg::*;

  localparam int AW = $clog2(MAX_SPINS * MAX_SPINS);
  localparam int SW = $clog2(MAX_SPINS);
  localparam int NW = $clog2(MAX_SPINS + 1);
  localparam int CW = MAX_SPINS + 1;
  localparam int CB_HI = (1 << (COUPLING_BITS - 1)) - 1;
  localparam int CB_LO = -(1 << (COUPLING_BITS - 1));
  localparam int SAT_HI = (CB_HI > ONE_Q14) ? ONE_Q14 : CB_HI;
  localparam int SAT_LO = (CB_LO < -ONE_Q14) ? -ONE_Q14 : CB_LO;

  state_t state, state_next;

  logic [3:0]  spin_count;
  logic [60:0] part_reg;
  logic        part_valid;

  mode_t                     op_mode;
  logic [2:0]                op_row, op_col;
  logic                      wr_ok;
  logic signed [COUPLING_BITS-1:0] op_val;
  logic [MAX_SPINS-1:0]      cur_cfg;
  logic [CW-1:0]             cfg_cnt;

  logic [SW-1:0]             pi, pj;
  logic signed [19:0]        h;
  logic signed [COUPLING_BITS-1:0] rd_data;
  logic signed [COUPLING_BITS-1:0] mem [MAX_SPINS*MAX_SPINS];

  logic signed [36:0]        xr;
  logic signed [7:0]         xq;
  logic [30:0]               term;
  logic [31:0]               sum;
  logic [3:0]                k;
  logic [60:0]               mul;
  logic [30:0]               dnum;
  logic [4:0]                drem;
  logic [4:0]                dcnt;
  logic [57:0]               e16;
  logic [60:0]               e8;
  logic [60:0]               e8_now;
  logic [60:0]               z_acc;
  logic [61:0]               prem;
  logic [16:0]               pq;

  logic              o_status;
  logic signed [19:0] o_energy;
  logic [16:0]       o_prob;
  logic [60:0]       o_part;

  logic [NW-1:0]     n_used;
  logic              in_acc, out_free, cfg_wr, mem_we;
  logic [AW-1:0]     mem_waddr, rd_addr;
  logic              pair_last, cfg_last;
  logic              dbit;
  logic [5:0]        dtry;
  logic [61:0]       ptry;
  logic signed [7:0] sh;
  logic [63:0]       shifted;
  logic [6:0]        dsh;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SPIN_COUNT);
  assign prdata = (paddr[2] == REG_SPIN_COUNT) ? {28'd0, spin_count} : 32'd0;

  always_comb begin
    if (spin_count == 4'd0) begin
      n_used = NW'(1);
    end else if (int'(spin_count) > MAX_SPINS) begin
      n_used = NW'(MAX_SPINS);
    end else begin
      n_used = NW'(spin_count);
    end
  end

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_addr  = AW'(int'(pi) * MAX_SPINS + int'(pj));
  assign pair_last = (int'(pj) == int'(n_used) - 1) && (int'(pi) == int'(n_used) - 2);
  assign cfg_last  = (int'(cfg_cnt) == (1 << n_used) - 1);
  assign dtry = {drem, dnum[30]};
  assign dbit = (dtry >= {2'b00, k});
  assign ptry = {prem[60:0], 1'b0};
  assign sh   = xq - 8'sd14;
  assign dsh  = 7'(-int'(sh));
  assign e8_now = {11'd0, 50'((e16 + 58'd128) >> 8)};

  always_comb begin
    if (sh >= 0) begin
      shifted = {32'd0, sum} << sh[5:0];
    end else begin
      shifted = ({32'd0, sum} + (64'd1 << (dsh - 7'd1))) >> dsh;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(s_tuser))
            MODE_WRITE: state_next = S_WR1;
            MODE_PART, MODE_QUERY: state_next = (n_used == NW'(1)) ? S_PACC : S_PREAD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WR1: state_next = S_WR2;
      S_WR2: state_next = S_DONE;
      S_PREAD: state_next = S_PACC;
      S_PACC: begin
        if (n_used != NW'(1) && !pair_last) begin
          state_next = S_PREAD;
        end else if (op_mode == MODE_PART) begin
          state_next = S_XINIT;
        end else if (!part_valid || part_reg == 61'd0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_XINIT;
        end
      end
      S_XINIT: state_next = S_QRED;
      S_QRED: begin
        if (!xr[36] && xr < $signed(LN2_Q30)) state_next = S_MUL;
      end
      S_MUL:   state_next = S_DLOAD;
      S_DLOAD: state_next = S_DIV;
      S_DIV:   if (dcnt == 5'd30) state_next = S_TERM;
      S_TERM:  state_next = (k == EXP_TERMS) ? S_SCALE : S_MUL;
      S_SCALE: state_next = S_ROUND;
      S_ROUND: begin
        if (op_mode == MODE_PART) begin
          state_next = S_ZACC;
        end else if (e8_now >= part_reg) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PDIV;
        end
      end
      S_ZACC: begin
        if (cfg_last) begin
          state_next = S_DONE;
        end else begin
          state_next = (n_used == NW'(1)) ? S_PACC : S_PREAD;
        end
      end
      S_PDIV: if (dcnt == 5'd15) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    mem_we    = ((state == S_WR1) || (state == S_WR2)) && wr_ok;
    mem_waddr = (state == S_WR1) ? AW'(int'(op_row) * MAX_SPINS + int'(op_col))
                                 : AW'(int'(op_col) * MAX_SPINS + int'(op_row));
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= op_val;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      spin_count <= SPIN_RESET;
      part_reg   <= 61'd0;
      part_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        spin_count <= pwdata[3:0];
        part_reg   <= 61'd0;
        part_valid <= 1'b0;
      end
      if (state == S_WR2 && wr_ok) begin
        part_reg   <= 61'd0;
        part_valid <= 1'b0;
      end
      if (state == S_ZACC && cfg_last) begin
        part_reg   <= z_acc + e8;
        part_valid <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          op_mode <= mode_t'(s_tuser);
          op_row  <= s_tdata[2:0];
          op_col  <= s_tdata[5:3];
          wr_ok   <= (int'(s_tdata[2:0]) < MAX_SPINS) && (int'(s_tdata[5:3]) < MAX_SPINS);
          if (int'($signed(s_tdata[21:6])) > SAT_HI) begin
            op_val <= COUPLING_BITS'(SAT_HI);
          end else if (int'($signed(s_tdata[21:6])) < SAT_LO) begin
            op_val <= COUPLING_BITS'(SAT_LO);
          end else begin
            op_val <= COUPLING_BITS'(int'($signed(s_tdata[21:6])));
          end
          cur_cfg <= (mode_t'(s_tuser) == MODE_PART) ? '0
                     : (MAX_SPINS'(s_tdata[29:22]) & MAX_SPINS'((1 << n_used) - 1));
          cfg_cnt <= '0;
          z_acc   <= 61'd0;
          h       <= 20'sd0;
          pi      <= '0;
          pj      <= SW'(1);
          pq      <= 17'd0;
        end
      end
      S_PACC: begin
        if (n_used != NW'(1)) begin
          if (cur_cfg[pi] ^ cur_cfg[pj]) begin
            h <= h - 20'(rd_data);
          end else begin
            h <= h + 20'(rd_data);
          end
          if (int'(pj) == int'(n_used) - 1) begin
            pi <= pi + SW'(1);
            pj <= SW'(int'(pi) + 2);
          end else begin
            pj <= pj + SW'(1);
          end
        end
      end
      S_XINIT: begin
        xr   <= {h[19], h, 16'd0};
        xq   <= 8'sd0;
        term <= 31'd1 << 30;
        sum  <= 32'd1 << 30;
        k    <= 4'd1;
      end
      S_QRED: begin
        if (xr[36]) begin
          xr <= xr + $signed(LN2_Q30);
          xq <= xq - 8'sd1;
        end else if (xr >= $signed(LN2_Q30)) begin
          xr <= xr - $signed(LN2_Q30);
          xq <= xq + 8'sd1;
        end
      end
      S_MUL: mul <= term * xr[29:0];
      S_DLOAD: begin
        dnum <= mul[60:30];
        drem <= 5'd0;
        dcnt <= 5'd0;
      end
      S_DIV: begin
        drem <= dbit ? 5'(dtry - {2'b00, k}) : dtry[4:0];
        dnum <= {dnum[29:0], dbit};
        dcnt <= dcnt + 5'd1;
      end
      S_TERM: begin
        term <= dnum;
        sum  <= sum + {1'b0, dnum};
        k    <= k + 4'd1;
      end
      S_SCALE: e16 <= shifted[57:0];
      S_ROUND: begin
        e8   <= e8_now;
        prem <= {1'b0, e8_now};
        dcnt <= 5'd0;
        if (op_mode == MODE_QUERY && e8_now >= part_reg) begin
          pq <= 17'd65536;
        end
      end
      S_ZACC: begin
        z_acc   <= z_acc + e8;
        cfg_cnt <= cfg_cnt + CW'(1);
        cur_cfg <= MAX_SPINS'(cfg_cnt + CW'(1));
        h       <= 20'sd0;
        pi      <= '0;
        pj      <= SW'(1);
      end
      S_PDIV: begin
        if (ptry >= {1'b0, part_reg}) begin
          prem <= ptry - {1'b0, part_reg};
          pq   <= {pq[15:0], 1'b1};
        end else begin
          prem <= ptry;
          pq   <= {pq[15:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
      end
      S_DONE: begin
        if (out_free) begin
          o_status <= (op_mode == MODE_QUERY && !part_valid) ? STATUS_NOZ : STATUS_OK;
          o_energy <= (op_mode == MODE_QUERY) ? h : 20'sd0;
          o_prob   <= (op_mode == MODE_QUERY) ? pq : 17'd0;
          o_part   <= (op_mode == MODE_PART || op_mode == MODE_QUERY) ? part_reg : 61'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {6'd0, o_part, o_prob, o_energy};
  assign m_tuser = o_status;

endmodule
